[rtl/luma_digit_text_overlay_assert.svh]
// Assertion helpers shared by the overlay RTL.
`ifndef LUMA_DIGIT_TEXT_OVERLAY_ASSERT_SVH
`define LUMA_DIGIT_TEXT_OVERLAY_ASSERT_SVH

// Condition holds at every edge outside reset.
`define LDTO_ASSERT_HOLDS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define LDTO_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ldto_pkg.sv]
package ldto_pkg;

  localparam int CoordBits   = 16;
  localparam int CropDigits  = 5;
  localparam int CropSlots   = 23;
  localparam int SlotBits    = 5;
  localparam int StampDigits = 20;
  localparam int StampBits   = 5;
  localparam int AddrBits    = 6;
  localparam int QueueDepth  = 4;

  localparam logic [7:0] WhiteLuma = 8'd235;
  localparam logic [3:0] CommaCode = 4'd10;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_CROP_VALID    = 3'd2,
    REG_CROP_LEFT     = 3'd3,
    REG_CROP_TOP      = 3'd4,
    REG_CROP_SPAN_X   = 3'd5,
    REG_CROP_SPAN_Y   = 3'd6,
    REG_CAPTURE_STAMP = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [CoordBits-1:0] pixel_x;
    logic [CoordBits-1:0] pixel_y;
    logic [7:0]           luma_in;
    logic [7:0]           chroma_in;
  } pixel_t;

  typedef struct packed {
    logic [7:0] luma_out;
    logic [7:0] chroma_out;
    logic       glyph_hit;
  } result_t;

  typedef struct packed {
    logic [3:0] code;
    logic [7:0] start;
  } crop_slot_t;

  typedef struct packed {
    logic                           busy;
    logic [CoordBits-1:0]           frame_width;
    logic [CoordBits-1:0]           frame_height;
    logic [SlotBits-1:0]            crop_count;
    crop_slot_t [CropSlots-1:0]     slots;
    logic [StampBits-1:0]           stamp_len;
    logic [StampBits-1:0]           stamp_count;
    logic [StampDigits-1:0][3:0]    stamp_bcd;
  } layout_t;

  typedef struct packed {
    logic [7:0]           luma;
    logic [7:0]           chroma;
    logic                 l1;
    logic [3:0]           code1;
    logic [2:0]           dx1;
    logic [2:0]           ry1;
    logic                 l2;
    logic [StampBits-1:0] idx2;
    logic [1:0]           col2;
    logic [2:0]           ry2;
  } entry_t;

  function automatic logic [0:4][2:0] font_rows(input logic [3:0] code);
    logic [0:4][2:0] r;
    case (code)
      4'd0: r = '{3'd7, 3'd5, 3'd5, 3'd5, 3'd7};
      4'd1: r = '{3'd2, 3'd6, 3'd2, 3'd2, 3'd7};
      4'd2: r = '{3'd7, 3'd1, 3'd7, 3'd4, 3'd7};
      4'd3: r = '{3'd7, 3'd1, 3'd7, 3'd1, 3'd7};
      4'd4: r = '{3'd5, 3'd5, 3'd7, 3'd1, 3'd1};
      4'd5: r = '{3'd7, 3'd4, 3'd7, 3'd1, 3'd7};
      4'd6: r = '{3'd7, 3'd4, 3'd7, 3'd5, 3'd7};
      4'd7: r = '{3'd7, 3'd1, 3'd1, 3'd1, 3'd1};
      4'd8: r = '{3'd7, 3'd5, 3'd7, 3'd5, 3'd7};
      4'd9: r = '{3'd7, 3'd5, 3'd7, 3'd1, 3'd7};
      default: r = '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0};
    endcase
    return r;
  endfunction

  function automatic logic glyph_bit(input logic [3:0] code, input logic [2:0] row,
                                     input logic [1:0] col);
    logic [0:4][2:0] r;
    logic [2:0]      line;
    r = font_rows(code);
    line = (row < 3'd5) ? r[row] : 3'd0;
    return (col < 2'd3) ? line[2'd2 - col] : 1'b0;
  endfunction

endpackage

[rtl/ldto_cfg.sv]
`include "luma_digit_text_overlay_assert.svh"

module ldto_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ldto_pkg::AddrBits-1:0] paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output ldto_pkg::layout_t            layout
);
  import ldto_pkg::*;

  typedef enum logic [3:0] {
    ST_LOAD = 4'b0001,
    ST_CONV = 4'b0010,
    ST_WALK = 4'b0100,
    ST_IDLE = 4'b1000
  } state_t;

  state_t state;

  logic [CoordBits-1:0] frame_width, frame_height;
  logic                 crop_on;
  logic [15:0]          crop_left, crop_top, crop_span_x, crop_span_y;
  logic [63:0]          capture_stamp;

  logic [3:0][15:0]                 crop_sh;
  logic [3:0][CropDigits-1:0][3:0]  crop_bcd;
  logic [63:0]                      stamp_sh;
  logic [StampDigits-1:0][3:0]      stamp_bcd;
  logic [5:0]                       cnt;

  logic [3:0][CropDigits-1:0][3:0]  crop_bcd_next;
  logic [StampDigits-1:0][3:0]      stamp_bcd_next;

  logic [1:0]           vi;
  logic [2:0]           p;
  logic                 comma;
  logic [8:0]           x;
  logic [SlotBits-1:0]  n;
  logic                 cdone;
  logic [StampBits-1:0] sc;
  logic                 sdone;
  logic [StampBits-1:0] stamp_len;
  crop_slot_t [CropSlots-1:0] slots;

  logic                 wr;
  reg_idx_t             widx;
  logic [2:0]           len_v;
  logic [StampBits-1:0] stamp_len_c;
  logic [3:0]           sym;
  logic [3:0]           adv;
  logic [2:0]           didx;
  logic                 cut;
  logic [8:0]           s_end;

  assign wr   = psel && penable && pwrite;
  assign widx = reg_idx_t'(paddr[AddrBits-1:3]);

  function automatic logic [3:0] dd_adj(input logic [3:0] d);
    return (d >= 4'd5) ? d + 4'd3 : d;
  endfunction

  always_comb begin
    logic [CropDigits*4-1:0]  ct;
    logic [StampDigits*4-1:0] st;
    for (int k = 0; k < 4; k++) begin
      for (int d = 0; d < CropDigits; d++) begin
        ct[d*4 +: 4] = dd_adj(crop_bcd[k][d]);
      end
      crop_bcd_next[k] = {ct[CropDigits*4-2:0], crop_sh[k][15]};
    end
    for (int d = 0; d < StampDigits; d++) begin
      st[d*4 +: 4] = dd_adj(stamp_bcd[d]);
    end
    stamp_bcd_next = {st[StampDigits*4-2:0], stamp_sh[63]};
  end

  always_comb begin
    len_v = 3'd1;
    for (int d = 1; d < CropDigits; d++) begin
      if (crop_bcd[vi][d] != 4'd0) len_v = 3'(d + 1);
    end
    stamp_len_c = 5'd1;
    for (int d = 1; d < StampDigits; d++) begin
      if (stamp_bcd[d] != 4'd0) stamp_len_c = 5'(d + 1);
    end
  end

  always_comb begin
    didx  = len_v - 3'd1 - p;
    sym   = comma ? CommaCode : crop_bcd[vi][didx];
    adv   = comma ? 4'd4 : 4'd8;
    cut   = ({8'd0, x} + {13'd0, adv}) >= {1'b0, frame_width};
    s_end = 9'd8 + {1'b0, (6'({1'b0, sc}) + 6'd1), 2'b00};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      frame_width   <= 16'd640;
      frame_height  <= 16'd480;
      crop_on       <= 1'b0;
      crop_left     <= '0;
      crop_top      <= '0;
      crop_span_x   <= '0;
      crop_span_y   <= '0;
      capture_stamp <= '0;
      n             <= '0;
      sc            <= '0;
    end else if (wr) begin
      state <= ST_LOAD;
      case (widx)
        REG_FRAME_WIDTH:   frame_width   <= pwdata[CoordBits-1:0];
        REG_FRAME_HEIGHT:  frame_height  <= pwdata[CoordBits-1:0];
        REG_CROP_VALID:    crop_on       <= pwdata[0];
        REG_CROP_LEFT:     crop_left     <= pwdata[15:0];
        REG_CROP_TOP:      crop_top      <= pwdata[15:0];
        REG_CROP_SPAN_X:   crop_span_x   <= pwdata[15:0];
        REG_CROP_SPAN_Y:   crop_span_y   <= pwdata[15:0];
        REG_CAPTURE_STAMP: capture_stamp <= pwdata;
        default: ;
      endcase
    end else begin
      case (state)
        ST_LOAD: begin
          crop_sh[0] <= crop_on ? crop_left   : 16'd0;
          crop_sh[1] <= crop_on ? crop_top    : 16'd0;
          crop_sh[2] <= crop_on ? crop_span_x : 16'd0;
          crop_sh[3] <= crop_on ? crop_span_y : 16'd0;
          stamp_sh   <= capture_stamp;
          crop_bcd   <= '0;
          stamp_bcd  <= '0;
          cnt        <= '0;
          vi         <= '0;
          p          <= '0;
          comma      <= 1'b0;
          x          <= 9'd8;
          n          <= '0;
          cdone      <= 1'b0;
          sc         <= '0;
          sdone      <= 1'b0;
          state      <= ST_CONV;
        end
        ST_CONV: begin
          cnt       <= cnt + 6'd1;
          stamp_sh  <= {stamp_sh[62:0], 1'b0};
          stamp_bcd <= stamp_bcd_next;
          if (cnt[5:4] == 2'd0) begin
            crop_bcd <= crop_bcd_next;
            for (int k = 0; k < 4; k++) crop_sh[k] <= {crop_sh[k][14:0], 1'b0};
          end
          if (cnt == 6'd63) state <= ST_WALK;
        end
        ST_WALK: begin
          stamp_len <= stamp_len_c;
          if (!cdone) begin
            if (cut) begin
              cdone <= 1'b1;
            end else begin
              slots[n[SlotBits-1:0]].code  <= sym;
              slots[n[SlotBits-1:0]].start <= 8'(x - 9'd8);
              n <= n + 5'd1;
              x <= x + {5'd0, adv};
              if (comma) begin
                comma <= 1'b0;
              end else if (p == len_v - 3'd1) begin
                if (vi == 2'd3) begin
                  cdone <= 1'b1;
                end else begin
                  vi    <= vi + 2'd1;
                  p     <= '0;
                  comma <= 1'b1;
                end
              end else begin
                p <= p + 3'd1;
              end
            end
          end
          if (!sdone) begin
            if (sc == stamp_len_c || {8'd0, s_end} >= {1'b0, frame_width}) sdone <= 1'b1;
            else sc <= sc + 5'd1;
          end
          if (cdone && sdone) state <= ST_IDLE;
        end
        ST_IDLE: ;
        default: state <= ST_LOAD;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[AddrBits-1:3]))
      REG_FRAME_WIDTH:   prdata = {48'd0, frame_width};
      REG_FRAME_HEIGHT:  prdata = {48'd0, frame_height};
      REG_CROP_VALID:    prdata = {63'd0, crop_on};
      REG_CROP_LEFT:     prdata = {48'd0, crop_left};
      REG_CROP_TOP:      prdata = {48'd0, crop_top};
      REG_CROP_SPAN_X:   prdata = {48'd0, crop_span_x};
      REG_CROP_SPAN_Y:   prdata = {48'd0, crop_span_y};
      REG_CAPTURE_STAMP: prdata = capture_stamp;
      default:           prdata = '0;
    endcase
  end

  always_comb begin
    layout.busy         = (state != ST_IDLE);
    layout.frame_width  = frame_width;
    layout.frame_height = frame_height;
    layout.crop_count   = n;
    layout.slots        = slots;
    layout.stamp_len    = stamp_len;
    layout.stamp_count  = sc;
    layout.stamp_bcd    = stamp_bcd;
  end

  `LDTO_ASSERT_NEXT(a_wr_reload, clk, rst, wr, state == ST_LOAD, "write did not restart layout")
  `LDTO_ASSERT_HOLDS(a_crop_cnt, clk, rst, n <= SlotBits'(CropSlots), "crop count overflow")
  `LDTO_ASSERT_HOLDS(a_stamp_cnt, clk, rst, (state != ST_IDLE) || (sc <= stamp_len),
                     "stamp count beyond digits")

endmodule

[rtl/ldto_front.sv]
module ldto_front (
  input  ldto_pkg::pixel_t  pixel,
  input  ldto_pkg::layout_t layout,
  output ldto_pkg::entry_t  entry
);
  import ldto_pkg::*;

  logic [CoordBits-1:0] px, py, u, dy1, dy2;
  logic                 in_frame, right, row1, row2;
  logic [CropSlots-1:0] hitv;
  logic [3:0]           code1;
  logic [2:0]           dx1;

  always_comb begin
    logic [8:0] s_end;
    logic [7:0] off;
    px       = pixel.pixel_x;
    py       = pixel.pixel_y;
    u        = px - CoordBits'(8);
    dy1      = py - CoordBits'(8);
    dy2      = py - CoordBits'(22);
    in_frame = (px < layout.frame_width) && (py < layout.frame_height);
    right    = px >= CoordBits'(8);
    row1     = (py >= CoordBits'(8)) && (py < CoordBits'(18));
    row2     = (py >= CoordBits'(22)) && (py < CoordBits'(27)) &&
               (layout.frame_height > CoordBits'(27));
    code1    = '0;
    dx1      = '0;
    for (int j = 0; j < CropSlots; j++) begin
      s_end   = {1'b0, layout.slots[j].start} +
                ((layout.slots[j].code == CommaCode) ? 9'd4 : 9'd8);
      hitv[j] = (SlotBits'(j) < layout.crop_count) &&
                (u[7:0] >= layout.slots[j].start) && ({1'b0, u[7:0]} < s_end);
      off     = u[7:0] - layout.slots[j].start;
      code1   = code1 | ({4{hitv[j]}} & layout.slots[j].code);
      dx1     = dx1 | ({3{hitv[j]}} & off[2:0]);
    end
    entry.luma   = pixel.luma_in;
    entry.chroma = pixel.chroma_in;
    entry.l1     = in_frame && row1 && right && (u[CoordBits-1:8] == '0) && (|hitv);
    entry.code1  = code1;
    entry.dx1    = dx1;
    entry.ry1    = dy1[3:1];
    entry.l2     = in_frame && row2 && right &&
                   (u < CoordBits'({layout.stamp_count, 2'b00}));
    entry.idx2   = u[StampBits+1:2];
    entry.col2   = u[1:0];
    entry.ry2    = dy2[2:0];
  end

endmodule

[rtl/ldto_queue.sv]
`include "luma_digit_text_overlay_assert.svh"

module ldto_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ldto_pkg::entry_t wdata,
  input  logic             pop,
  output ldto_pkg::entry_t rdata,
  output logic             empty,
  output logic             full
);
  import ldto_pkg::*;

  entry_t     mem [QueueDepth];
  logic [1:0] wp, rp;
  logic [2:0] count;

  assign empty = (count == 3'd0);
  assign full  = (count == 3'(QueueDepth));
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 2'd1;
      if (pop)  rp <= rp + 2'd1;
      case ({push, pop})
        2'b10:   count <= count + 3'd1;
        2'b01:   count <= count - 3'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
  end

  `LDTO_ASSERT_HOLDS(a_q_bound, clk, rst, count <= 3'(QueueDepth), "queue overfilled")
  `LDTO_ASSERT_HOLDS(a_q_pop, clk, rst, !pop || (count != 3'd0), "pop from empty queue")
  `LDTO_ASSERT_NEXT(a_q_push, clk, rst, push && !pop, count == $past(count) + 3'd1,
                    "push not counted")

endmodule

[rtl/ldto_back.sv]
module ldto_back (
  input  logic              clk,
  input  logic              rst,
  input  ldto_pkg::entry_t  head,
  input  logic              empty,
  output logic              pop,
  input  ldto_pkg::layout_t layout,
  output logic              result_valid,
  input  logic              result_ready,
  output ldto_pkg::result_t result
);
  import ldto_pkg::*;

  logic                 hit1, hit2, hit;
  logic [3:0]           d2;
  logic [StampBits-1:0] sidx;

  assign pop = !empty && (!result_valid || result_ready);

  always_comb begin
    sidx = layout.stamp_len - 5'd1 - head.idx2;
    d2   = layout.stamp_bcd[sidx];
    if (head.code1 == CommaCode) begin
      hit1 = head.l1 && (head.dx1[2:1] == 2'd1) && (head.ry1 == 3'd4);
    end else begin
      hit1 = head.l1 && glyph_bit(head.code1, head.ry1, head.dx1[2:1]);
    end
    hit2 = head.l2 && glyph_bit(d2, head.ry2, head.col2);
    hit  = hit1 || hit2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result.luma_out   <= hit ? WhiteLuma : head.luma;
      result.chroma_out <= head.chroma;
      result.glyph_hit  <= hit;
    end
  end

endmodule

[rtl/luma_digit_text_overlay.sv]
// channel   | direction | payload         | handshake
// pixel     | in        | pixel_t         | pixel_valid / pixel_ready
// result    | out       | result_t        | result_valid / result_ready
// apb       | in        | 64-bit regs @8i | psel, penable, pwrite, pready=1
// One pixel per cycle sustained while the layout is idle and result_ready is high;
// each result passes through the queue and the result register. A 4-entry queue sits
// between classification and glyph lookup. After reset and after every register write
// the text layout is rebuilt: a load, BCD shift conversion, then the layout walk; pixel_ready is low then.
// Stalls on result_ready back up through the queue to pixel_ready.
module luma_digit_text_overlay (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pixel_valid,
  output logic                          pixel_ready,
  input  ldto_pkg::pixel_t              pixel,
  output logic                          result_valid,
  input  logic                          result_ready,
  output ldto_pkg::result_t             result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ldto_pkg::AddrBits-1:0] paddr,
  input  logic [63:0]                   pwdata,
  output logic [63:0]                   prdata,
  output logic                          pready
);
  import ldto_pkg::*;

  layout_t layout;
  entry_t  entry, head;
  logic    empty, full, push, pop;

  assign pready      = 1'b1;
  assign pixel_ready = !layout.busy && !full;
  assign push        = pixel_valid && pixel_ready;

  ldto_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .layout
  );

  ldto_front u_front (
    .pixel, .layout, .entry
  );

  ldto_queue u_queue (
    .clk, .rst, .push, .wdata(entry), .pop, .rdata(head), .empty, .full
  );

  ldto_back u_back (
    .clk, .rst, .head, .empty, .pop, .layout, .result_valid, .result_ready, .result
  );

endmodule

[tb/luma_digit_text_overlay_tb.sv]
module luma_digit_text_overlay_tb;
  import ldto_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int CropMax    = 43;
  localparam int StampMax   = 20;

  localparam logic [2:0] FONT [10][5] = '{
    '{3'd7, 3'd5, 3'd5, 3'd5, 3'd7},
    '{3'd2, 3'd6, 3'd2, 3'd2, 3'd7},
    '{3'd7, 3'd1, 3'd7, 3'd4, 3'd7},
    '{3'd7, 3'd1, 3'd7, 3'd1, 3'd7},
    '{3'd5, 3'd5, 3'd7, 3'd1, 3'd1},
    '{3'd7, 3'd4, 3'd7, 3'd1, 3'd7},
    '{3'd7, 3'd4, 3'd7, 3'd5, 3'd7},
    '{3'd7, 3'd1, 3'd1, 3'd1, 3'd1},
    '{3'd7, 3'd5, 3'd7, 3'd5, 3'd7},
    '{3'd7, 3'd5, 3'd7, 3'd1, 3'd7}
  };

  logic                clk;
  logic                rst;
  logic                pixel_valid;
  logic                pixel_ready;
  pixel_t              pixel;
  logic                result_valid;
  logic                result_ready;
  result_t             result;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AddrBits-1:0] paddr;
  logic [63:0]         pwdata;
  logic [63:0]         prdata;
  logic                pready;

  luma_digit_text_overlay dut (
    .clk(clk), .rst(rst),
    .pixel_valid(pixel_valid), .pixel_ready(pixel_ready), .pixel(pixel),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // overlay settings as last written
  logic [15:0] cfg_width, cfg_height, cfg_left, cfg_top, cfg_span_x, cfg_span_y;
  logic        cfg_crop_on;
  logic [63:0] cfg_stamp;

  // derived text layout
  logic [3:0]  crop_code [CropMax];
  logic [31:0] crop_start [CropMax];
  int          crop_drawn;
  logic [3:0]  stamp_digit [StampMax];
  int          stamp_drawn;

  result_t     expected_px [$];
  int          errors;
  int          cycles;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_len;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int to_decimal(logic [63:0] v, ref logic [3:0] dst [CropMax],
                                    input int n);
    logic [3:0] tmp [StampMax];
    int k;
    k = 0;
    do begin
      tmp[k] = 4'(v % 10);
      k++;
      v = v / 10;
    end while (v != 0 && k < StampMax);
    while (k > 0) begin
      k--;
      dst[n] = tmp[k];
      n++;
    end
    return n;
  endfunction

  function automatic void relayout();
    logic [63:0] vals [4];
    logic [3:0]  tmp [StampMax];
    logic [63:0] v;
    logic [31:0] x, adv;
    int n, k;
    vals[0] = cfg_crop_on ? 64'(cfg_left) : 64'd0;
    vals[1] = cfg_crop_on ? 64'(cfg_top) : 64'd0;
    vals[2] = cfg_crop_on ? 64'(cfg_span_x) : 64'd0;
    vals[3] = cfg_crop_on ? 64'(cfg_span_y) : 64'd0;
    n = 0;
    for (int i = 0; i < CropMax; i++) begin
      crop_code[i] = '0;
      crop_start[i] = '0;
    end
    for (int i = 0; i < 4; i++) begin
      if (i > 0) begin
        crop_code[n] = CommaCode;
        n++;
      end
      n = to_decimal(vals[i], crop_code, n);
    end
    x = 8;
    crop_drawn = 0;
    for (int i = 0; i < n; i++) begin
      adv = (crop_code[i] == CommaCode) ? 4 : 8;
      if (x + adv >= {16'd0, cfg_width}) break;
      crop_start[i] = x;
      x += adv;
      crop_drawn++;
    end
    v = cfg_stamp;
    k = 0;
    do begin
      tmp[k] = 4'(v % 10);
      k++;
      v = v / 10;
    end while (v != 0 && k < StampMax);
    for (int i = 0; i < StampMax; i++) stamp_digit[i] = (i < k) ? tmp[k - 1 - i] : 4'd0;
    x = 8;
    stamp_drawn = 0;
    for (int i = 0; i < k; i++) begin
      if (x + 4 >= {16'd0, cfg_width}) break;
      x += 4;
      stamp_drawn++;
    end
  endfunction

  function automatic bit on_symbol(logic [3:0] sym, logic [31:0] x0, logic [31:0] y0,
                                   logic [31:0] s, logic [31:0] px, logic [31:0] py);
    logic [31:0] dx, dy;
    logic [2:0]  row;
    if (px < x0 || py < y0) return 0;
    dx = px - x0;
    dy = py - y0;
    if (sym == CommaCode) return dx >= s && dx < 2 * s && dy >= 4 * s && dy < 5 * s;
    if (sym > 9 || dx >= 3 * s || dy >= 5 * s) return 0;
    row = FONT[sym][dy / s];
    return row[2 - dx / s];
  endfunction

  function automatic result_t overlay_pixel(pixel_t p);
    result_t r;
    bit hit;
    hit = 0;
    if (p.pixel_x < cfg_width && p.pixel_y < cfg_height) begin
      for (int i = 0; i < crop_drawn && !hit; i++)
        hit = on_symbol(crop_code[i], crop_start[i], 32'd8, 32'd2,
                        32'(p.pixel_x), 32'(p.pixel_y));
      if (cfg_height > 27)
        for (int i = 0; i < stamp_drawn && !hit; i++)
          hit = on_symbol(stamp_digit[i], 32'(8 + 4 * i), 32'd22, 32'd1,
                          32'(p.pixel_x), 32'(p.pixel_y));
    end
    r.luma_out = hit ? WhiteLuma : p.luma_in;
    r.chroma_out = p.chroma_in;
    r.glyph_hit = hit;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [7:0] got, logic [7:0] want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", field, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_px.size() == 0) begin
          report_mismatch("unexpected result", result.luma_out, 8'd0);
        end else begin
          want = expected_px.pop_front();
          if (result.luma_out !== want.luma_out)
            report_mismatch("luma_out", result.luma_out, want.luma_out);
          if (result.chroma_out !== want.chroma_out)
            report_mismatch("chroma_out", result.chroma_out, want.chroma_out);
          if (result.glyph_hit !== want.glyph_hit)
            report_mismatch("glyph_hit", {7'd0, result.glyph_hit}, {7'd0, want.glyph_hit});
        end
      end
      if (hold_len > 0) begin
        hold_len--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_pixel(pixel_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel <= p;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
    expected_px.push_back(overlay_pixel(p));
  endtask

  task automatic drain();
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (expected_px.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:   cfg_width = value[15:0];
      REG_FRAME_HEIGHT:  cfg_height = value[15:0];
      REG_CROP_VALID:    cfg_crop_on = value[0];
      REG_CROP_LEFT:     cfg_left = value[15:0];
      REG_CROP_TOP:      cfg_top = value[15:0];
      REG_CROP_SPAN_X:   cfg_span_x = value[15:0];
      REG_CROP_SPAN_Y:   cfg_span_y = value[15:0];
      REG_CAPTURE_STAMP: cfg_stamp = value;
      default: ;
    endcase
    relayout();
  endtask

  task automatic set_overlay(logic [15:0] w, logic [15:0] h, logic on, logic [15:0] l,
                             logic [15:0] t, logic [15:0] sx, logic [15:0] sy,
                             logic [63:0] stamp);
    write_reg(REG_FRAME_WIDTH, 64'(w));
    write_reg(REG_FRAME_HEIGHT, 64'(h));
    write_reg(REG_CROP_VALID, 64'(on));
    write_reg(REG_CROP_LEFT, 64'(l));
    write_reg(REG_CROP_TOP, 64'(t));
    write_reg(REG_CROP_SPAN_X, 64'(sx));
    write_reg(REG_CROP_SPAN_Y, 64'(sy));
    write_reg(REG_CAPTURE_STAMP, stamp);
  endtask

  function automatic pixel_t pick_pixel();
    pixel_t p;
    int sel;
    sel = $urandom_range(99);
    p.luma_in = 8'($urandom);
    p.chroma_in = 8'($urandom);
    if (sel < 80) begin
      p.pixel_x = 16'($urandom_range(200));
      p.pixel_y = 16'($urandom_range(30));
    end else if (sel < 90) begin
      p.pixel_x = 16'(32'(cfg_width) + $urandom_range(4) - 32'd2);
      p.pixel_y = 16'(32'(cfg_height) + $urandom_range(4) - 32'd2);
    end else begin
      p.pixel_x = 16'($urandom);
      p.pixel_y = 16'($urandom);
    end
    return p;
  endfunction

  function automatic logic [15:0] pick_u16();
    case ($urandom_range(3))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(999));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_default_layout();
    pixel_t p;
    for (int y = 8; y < 18; y++) begin
      p = '{pixel_x: 16'(8 + $urandom_range(3)), pixel_y: 16'(y),
            luma_in: 8'd16, chroma_in: 8'd128};
      send_pixel(p);
    end
    send_pixel('{pixel_x: 16'd8, pixel_y: 16'd22, luma_in: 8'd0, chroma_in: 8'd255});
    send_pixel('{pixel_x: 16'd18, pixel_y: 16'd17, luma_in: 8'd255, chroma_in: 8'd0});
    drain();
  endtask

  task automatic test_extremes();
    set_overlay(16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                64'hFFFF_FFFF_FFFF_FFFF);
    send_pixel('{pixel_x: 16'hFFFF, pixel_y: 16'hFFFF, luma_in: 8'hFF, chroma_in: 8'hFF});
    send_pixel('{pixel_x: 16'd0, pixel_y: 16'd0, luma_in: 8'h00, chroma_in: 8'h00});
    send_pixel('{pixel_x: 16'd50, pixel_y: 16'd16, luma_in: 8'h5A, chroma_in: 8'hA5});
    send_pixel('{pixel_x: 16'd8, pixel_y: 16'd22, luma_in: 8'h01, chroma_in: 8'h02});
    drain();
    set_overlay(16'd0, 16'd0, 1'b1, 16'd7, 16'd3, 16'd1, 16'd9, 64'd5);
    send_pixel('{pixel_x: 16'd8, pixel_y: 16'd8, luma_in: 8'h10, chroma_in: 8'h20});
    drain();
    set_overlay(16'd1, 16'd27, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 64'd0);
    send_pixel('{pixel_x: 16'd0, pixel_y: 16'd0, luma_in: 8'h33, chroma_in: 8'h44});
    drain();
    set_overlay(16'd40, 16'd28, 1'b1, 16'd12, 16'd4, 16'd3, 16'd8, 64'd1234567);
    for (int i = 0; i < 6; i++) send_pixel(pick_pixel());
    drain();
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      set_overlay(($urandom_range(3) == 0) ? pick_u16() : 16'($urandom_range(20, 220)),
                  ($urandom_range(3) == 0) ? pick_u16() : 16'($urandom_range(20, 40)),
                  1'($urandom_range(1)), pick_u16(), pick_u16(), pick_u16(), pick_u16(),
                  ($urandom_range(1) == 1) ? {$urandom, $urandom} : 64'($urandom_range(99999)));
      for (int i = 0; i < 160; i++) send_pixel(pick_pixel());
      drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    hold_len = 300;
    for (int i = 0; i < 40; i++) send_pixel(pick_pixel());
    drain();
  endtask

  initial begin
    rst = 1'b1;
    pixel_valid = 1'b0;
    pixel = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_len = 0;
    cfg_width = 16'd640;
    cfg_height = 16'd480;
    cfg_crop_on = 1'b0;
    cfg_left = '0;
    cfg_top = '0;
    cfg_span_x = '0;
    cfg_span_y = '0;
    cfg_stamp = '0;
    relayout();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_layout();
    test_extremes();
    test_random_phases();
    test_backpressure();
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_px.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/ldto_pkg.sv
rtl/ldto_cfg.sv
rtl/ldto_front.sv
rtl/ldto_queue.sv
rtl/ldto_back.sv
rtl/luma_digit_text_overlay.sv
tb/luma_digit_text_overlay_tb.sv
